### sv/bqc_pkg.sv
// Shared constants, widths and types for the Q31 biquad cascade.
package bqc_pkg;

    localparam int MAX_STAGES = 8;
    localparam int TERMS      = 5;
    localparam int HIST_PER   = 4;
    localparam int COEF_SLOTS = MAX_STAGES * TERMS;
    localparam int HIST_SLOTS = MAX_STAGES * HIST_PER;

    localparam int CA_W   = $clog2(COEF_SLOTS);
    localparam int HA_W   = $clog2(HIST_SLOTS);
    localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NSTG_W = $clog2(MAX_STAGES + 1);
    localparam int CYC_W  = 3;

    // Per-stage schedule, in cycles from the start of the stage.
    localparam logic [CYC_W-1:0] CYC_RD_LAST   = 3'd4;
    localparam logic [CYC_W-1:0] CYC_MUL_FIRST = 3'd1;
    localparam logic [CYC_W-1:0] CYC_MUL_LAST  = 3'd5;
    localparam logic [CYC_W-1:0] CYC_ACC_FIRST = 3'd2;
    localparam logic [CYC_W-1:0] CYC_ACC_LAST  = 3'd6;
    localparam logic [CYC_W-1:0] CYC_CAP_X1    = 3'd2;
    localparam logic [CYC_W-1:0] CYC_CAP_Y1    = 3'd4;
    localparam logic [CYC_W-1:0] CYC_WB_X      = 3'd3;
    localparam logic [CYC_W-1:0] CYC_WB_X1     = 3'd4;
    localparam logic [CYC_W-1:0] CYC_WB_Y1     = 3'd5;
    localparam logic [CYC_W-1:0] CYC_END       = 3'd7;

    // History slot offsets within a stage.
    localparam int H_X1 = 0;
    localparam int H_X2 = 1;
    localparam int H_Y1 = 2;
    localparam int H_Y2 = 3;

    // Request types on the input channel.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Configuration register index (taken from paddr[2]).
    localparam logic REG_NUM_STAGES = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

### sv/biquad_cascade_q31.sv
// Top level of the Q31 direct-form-I biquad cascade with one shared multiply-accumulate unit.
// A word on the input channel either loads one coefficient (req_type 1, no result, and the
// channel stays ready) or filters one sample (req_type 0, exactly one result word). A sample
// runs through the active stages one after another on a single 32x32 multiplier followed
// by a rounding accumulator; each stage does five reads, the multiply and accumulate
// pipeline, and the history write-back. The coefficient and history stores are
// single-write, single-read memories with registered read data, and their reset-to-zero
// is provided by per-entry valid bits, so no clearing pass is needed after reset. The
// input channel is ready whenever the sequencer is idle, even while a finished result
// still waits in the output register. num_stages is written through the APB port at
// address 0; values above eight act as eight, and zero gives a result of zero without
// touching the history. Configuration should only be written while the block is idle.
module biquad_cascade_q31 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic signed [31:0] i_sample_in,
    input  logic [5:0]         i_coef_index,
    input  logic signed [31:0] i_coef_value,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_sample_out,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CA_W   = bqc_pkg::CA_W;
    localparam int HA_W   = bqc_pkg::HA_W;
    localparam int STG_W  = bqc_pkg::STG_W;
    localparam int NSTG_W = bqc_pkg::NSTG_W;
    localparam int CYC_W  = bqc_pkg::CYC_W;

    // Control state
    bqc_pkg::t_state r_state, n_state;
    logic [3:0]        r_num_stages;
    logic [NSTG_W-1:0] r_nstg;
    logic [STG_W-1:0]  r_stg;
    logic [CYC_W-1:0]  r_cyc;
    logic [CA_W-1:0]   r_cbase;
    logic [HA_W-1:0]   r_hbase;
    logic              r_out_valid;

    // Datapath
    logic [31:0]        r_x;
    logic [31:0]        r_x1;
    logic [31:0]        r_y1;
    logic [31:0]        r_acc;
    logic signed [63:0] r_prod;
    logic [31:0]        r_out_data;

    // Memories with per-entry valid bits standing in for the all-zero reset.
    logic [31:0]                    r_coef_mem [bqc_pkg::COEF_SLOTS];
    logic [bqc_pkg::COEF_SLOTS-1:0] r_coef_vld;
    logic [31:0]                    r_hist_mem [bqc_pkg::HIST_SLOTS];
    logic [bqc_pkg::HIST_SLOTS-1:0] r_hist_vld;
    logic [31:0]                    r_coef_q;
    logic                           r_coef_q_vld;
    logic [31:0]                    r_hist_q;
    logic                           r_hist_q_vld;

    // FSM outputs and handshake terms
    logic in_fire, out_fire, out_free, done_fire, stage_end, last_stage;

    // Read and write port controls
    logic            coef_rd_en, hist_rd_en;
    logic [CA_W-1:0] coef_raddr;
    logic [HA_W-1:0] hist_raddr;
    logic            coef_we;
    logic [CA_W-1:0] coef_waddr;
    logic            hist_we;
    logic [HA_W-1:0] hist_waddr;
    logic [31:0]     hist_wdata;

    // Arithmetic
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [31:0]        rnd_hi;
    logic [31:0]        y_new;
    logic [NSTG_W-1:0]  nstg_clamped;
    logic               cfg_we;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == 3'd0);

    always_comb begin
        prdata = '0;
        if (paddr[2] == bqc_pkg::REG_NUM_STAGES) begin
            prdata = {28'd0, r_num_stages};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_stages <= 4'd1;
        end else if (cfg_we) begin
            r_num_stages <= pwdata[3:0];
        end
    end

    // A count beyond the number of built stages acts as the maximum.
    assign nstg_clamped = (32'(r_num_stages) > bqc_pkg::MAX_STAGES)
                          ? NSTG_W'(bqc_pkg::MAX_STAGES) : NSTG_W'(r_num_stages);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign last_stage = (NSTG_W'(r_stg) + NSTG_W'(1)) == r_nstg;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bqc_pkg::ST_IDLE: begin
                if (in_fire && i_req_type == bqc_pkg::REQ_SAMPLE) begin
                    n_state = (nstg_clamped == '0) ? bqc_pkg::ST_DONE : bqc_pkg::ST_RUN;
                end
            end
            bqc_pkg::ST_RUN: begin
                if (r_cyc == bqc_pkg::CYC_END && last_stage) begin
                    n_state = bqc_pkg::ST_DONE;
                end
            end
            bqc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = bqc_pkg::ST_IDLE;
                end
            end
            default: n_state = bqc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        done_fire  = 1'b0;
        stage_end  = 1'b0;
        unique case (r_state)
            bqc_pkg::ST_IDLE: o_in_ready = 1'b1;
            bqc_pkg::ST_RUN:  stage_end  = (r_cyc == bqc_pkg::CYC_END);
            bqc_pkg::ST_DONE: done_fire  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bqc_pkg::ST_IDLE;
            r_cyc   <= '0;
            r_stg   <= '0;
            r_cbase <= '0;
            r_hbase <= '0;
            r_nstg  <= '0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_cyc   <= '0;
                r_stg   <= '0;
                r_cbase <= '0;
                r_hbase <= '0;
                r_nstg  <= nstg_clamped;
            end else if (stage_end) begin
                r_cyc   <= '0;
                r_stg   <= r_stg + STG_W'(1);
                r_cbase <= r_cbase + CA_W'(bqc_pkg::TERMS);
                r_hbase <= r_hbase + HA_W'(bqc_pkg::HIST_PER);
            end else if (r_state == bqc_pkg::ST_RUN) begin
                r_cyc <= r_cyc + CYC_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    // Coefficient for term t is read in cycle t; the history word that term t uses
    // (x1, x2, y1, y2 for terms one to four) is read in the same cycle.
    assign coef_rd_en = (r_state == bqc_pkg::ST_RUN) && (r_cyc <= bqc_pkg::CYC_RD_LAST);
    assign coef_raddr = r_cbase + CA_W'(r_cyc);
    assign hist_rd_en = coef_rd_en && (r_cyc != '0);
    assign hist_raddr = r_hbase + HA_W'(r_cyc - CYC_W'(1));

    assign coef_we    = in_fire && (i_req_type == bqc_pkg::REQ_COEF)
                        && (32'(i_coef_index) < bqc_pkg::COEF_SLOTS);
    assign coef_waddr = CA_W'(i_coef_index);

    assign y_new = {r_acc[30:0], 1'b0};

    // History write-back: each slot is rewritten only after its old value was read.
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_hbase;
        hist_wdata = r_x;
        if (r_state == bqc_pkg::ST_RUN) begin
            unique case (r_cyc)
                bqc_pkg::CYC_WB_X: begin
                    hist_we    = 1'b1;
                    hist_waddr = r_hbase + HA_W'(bqc_pkg::H_X1);
                    hist_wdata = r_x;
                end
                bqc_pkg::CYC_WB_X1: begin
                    hist_we    = 1'b1;
                    hist_waddr = r_hbase + HA_W'(bqc_pkg::H_X2);
                    hist_wdata = r_x1;
                end
                bqc_pkg::CYC_WB_Y1: begin
                    hist_we    = 1'b1;
                    hist_waddr = r_hbase + HA_W'(bqc_pkg::H_Y2);
                    hist_wdata = r_y1;
                end
                bqc_pkg::CYC_END: begin
                    hist_we    = 1'b1;
                    hist_waddr = r_hbase + HA_W'(bqc_pkg::H_Y1);
                    hist_wdata = y_new;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= i_coef_value;
        end
        if (coef_rd_en) begin
            r_coef_q <= r_coef_mem[coef_raddr];
        end
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_rd_en) begin
            r_hist_q <= r_hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld   <= '0;
            r_hist_vld   <= '0;
            r_coef_q_vld <= 1'b0;
            r_hist_q_vld <= 1'b0;
        end else begin
            if (coef_we) begin
                r_coef_vld[coef_waddr] <= 1'b1;
            end
            if (hist_we) begin
                r_hist_vld[hist_waddr] <= 1'b1;
            end
            if (coef_rd_en) begin
                r_coef_q_vld <= r_coef_vld[coef_raddr];
            end
            if (hist_rd_en) begin
                r_hist_q_vld <= r_hist_vld[hist_raddr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiply and rounding accumulator
    // ------------------------------------------------------------------
    assign mul_a = r_coef_q_vld ? signed'(r_coef_q) : 32'sd0;
    assign mul_b = (r_cyc == bqc_pkg::CYC_MUL_FIRST) ? signed'(r_x)
                 : (r_hist_q_vld ? signed'(r_hist_q) : 32'sd0);
    assign mul_p = mul_a * mul_b;

    // High word of (product + 2^31): the rounding constant carries out of the low word
    // exactly when bit 31 of the product is set.
    assign rnd_hi = r_prod[63:32] + {31'd0, r_prod[31]};

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= (nstg_clamped == '0) ? 32'd0 : i_sample_in;
        end else if (stage_end) begin
            r_x <= y_new;
        end
        if (r_state == bqc_pkg::ST_RUN) begin
            if (r_cyc >= bqc_pkg::CYC_MUL_FIRST && r_cyc <= bqc_pkg::CYC_MUL_LAST) begin
                r_prod <= mul_p;
            end
            if (r_cyc == bqc_pkg::CYC_CAP_X1) begin
                r_x1 <= mul_b;
            end
            if (r_cyc == bqc_pkg::CYC_CAP_Y1) begin
                r_y1 <= mul_b;
            end
            if (r_cyc == bqc_pkg::CYC_ACC_FIRST) begin
                r_acc <= rnd_hi;
            end else if (r_cyc > bqc_pkg::CYC_ACC_FIRST && r_cyc <= bqc_pkg::CYC_ACC_LAST) begin
                r_acc <= r_acc + rnd_hi;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_data <= r_x;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = signed'(r_out_data);

endmodule

### tb/bqc_cascade_check.sv
// Channel monitor for the Q31 biquad cascade: predicts every output word and compares it.
module bqc_cascade_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_sample_in,
    input  logic [5:0]  i_coef_index,
    input  logic [31:0] i_coef_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_sample_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] coef_mem [bqc_pkg::COEF_SLOTS];
    logic [31:0] hist_mem [bqc_pkg::HIST_SLOTS];
    logic [3:0]  stages_cfg;
    logic [31:0] expected_samples [$];
    int          fail_total = 0;

    // High word of (acc << 32) + c*d + 2^31, all modulo 2^64.
    function automatic logic [31:0] mac_round_hi(input logic [31:0] acc, input logic [31:0] c,
                                                 input logic [31:0] d);
        logic signed [63:0] cw;
        logic signed [63:0] dw;
        logic [63:0]        sum;
        cw  = $signed(c);
        dw  = $signed(d);
        sum = {acc, 32'd0} + 64'(cw * dw) + 64'h0000_0000_8000_0000;
        return sum[63:32];
    endfunction

    // Runs one sample through the active sections and updates their history.
    function automatic logic [31:0] run_cascade(input logic [31:0] x_in);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] acc;
        logic [31:0] taps [bqc_pkg::TERMS];
        int          active;
        int          hb;
        x      = x_in;
        y      = '0;
        active = (stages_cfg > bqc_pkg::MAX_STAGES) ? bqc_pkg::MAX_STAGES : int'(stages_cfg);
        for (int s = 0; s < active; s++) begin
            hb   = s * bqc_pkg::HIST_PER;
            taps = '{x, hist_mem[hb + bqc_pkg::H_X1], hist_mem[hb + bqc_pkg::H_X2],
                     hist_mem[hb + bqc_pkg::H_Y1], hist_mem[hb + bqc_pkg::H_Y2]};
            acc  = '0;
            for (int t = 0; t < bqc_pkg::TERMS; t++) begin
                acc = mac_round_hi(acc, coef_mem[s * bqc_pkg::TERMS + t], taps[t]);
            end
            y = acc << 1;
            hist_mem[hb + bqc_pkg::H_X2] = hist_mem[hb + bqc_pkg::H_X1];
            hist_mem[hb + bqc_pkg::H_X1] = x;
            hist_mem[hb + bqc_pkg::H_Y2] = hist_mem[hb + bqc_pkg::H_Y1];
            hist_mem[hb + bqc_pkg::H_Y1] = y;
            x = y;
        end
        return y;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            foreach (coef_mem[k]) coef_mem[k] = '0;
            foreach (hist_mem[k]) hist_mem[k] = '0;
            stages_cfg = 4'd1;
            expected_samples.delete();
        end else begin
            if (i_psel && i_penable && !i_pwrite && i_pready
                && i_paddr[2] == bqc_pkg::REG_NUM_STAGES) begin
                if (i_prdata !== {28'd0, stages_cfg}) begin
                    report_mismatch($sformatf("num_stages read %08h, expected %08h",
                                              i_prdata, {28'd0, stages_cfg}));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[2] == bqc_pkg::REG_NUM_STAGES) begin
                stages_cfg = i_pwdata[3:0];
            end
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == bqc_pkg::REQ_COEF) begin
                    if (i_coef_index < bqc_pkg::COEF_SLOTS) begin
                        coef_mem[i_coef_index] = i_coef_value;
                    end
                end else begin
                    expected_samples.push_back(run_cascade(i_sample_in));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("output word %08h with nothing expected",
                                              i_sample_out));
                end else begin
                    want = expected_samples.pop_front();
                    if (i_sample_out !== want) begin
                        report_mismatch($sformatf("sample_out %08h, expected %08h",
                                                  i_sample_out, want));
                    end
                end
            end
        end
        o_pending    <= expected_samples.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/tb_top.sv
// Stimulus, handshake idling and verdict for the Q31 biquad cascade.
module tb_top;

    localparam int          RESET_CYCLES  = 10;
    localparam int          TARGET_ITEMS  = 1700;
    // Long enough for a sample with every section active to pass through the block.
    localparam int          SETTLE_CYCLES = 8 * bqc_pkg::MAX_STAGES + 2 + 8;
    localparam int          RX_HOLD       = 400;
    localparam int          QUIET_LIMIT   = 3000;
    localparam int          COEF_IDX_MAX  = 63;
    localparam logic [2:0]  ADDR_NUM_STAGES = {bqc_pkg::REG_NUM_STAGES, 2'b00};
    // Byte address of a register that does not exist; writes there must be dropped.
    localparam logic [2:0]  ADDR_UNMAPPED   = 3'b100;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_req_type;
    logic signed [31:0] i_sample_in;
    logic [5:0]         i_coef_index;
    logic signed [31:0] i_coef_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_sample_out;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int pending;
    int items_sent   = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int quiet_cycles = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    biquad_cascade_q31 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // The monitor sees exactly what the block sees and works out every expected word itself.
    bqc_cascade_check cascade_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Gap lengths: mostly short, now and then a long one. The sender may also
    // go straight on to the next word.
    function automatic int pick_gap(input bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(16, 100);
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Sample styles: full-scale noise, quiet signal (about 20 bits), or a mix of both.
    function automatic logic [31:0] pick_sample(input int style);
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 9) == 0) return pick_extreme();
        if (style == 1 || (style == 2 && v[31])) return {{12{v[19]}}, v[19:0]};
        return v;
    endfunction

    // Coefficient styles: any word, a modest filter-like magnitude, or extremes only.
    function automatic logic [31:0] pick_coef(input int style);
        logic [31:0] v;
        v = $urandom();
        if (style == 2 || $urandom_range(0, 9) == 0) return pick_extreme();
        if (style == 1) return {{3{v[28]}}, v[28:0]};
        return v;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid is left high, so a
    // following call keeps the channel busy without a bubble.
    task automatic send_word(input logic req, input logic [31:0] sample, input logic [5:0] slot,
                             input logic [31:0] value);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_sample_in  <= sample;
        i_coef_index <= slot;
        i_coef_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic [31:0] sample);
        send_word(bqc_pkg::REQ_SAMPLE, sample, 6'($urandom()), $urandom());
        items_sent++;
    endtask

    // Slots past the end of the table are dropped by the block and do not count as items.
    task automatic send_coef(input int slot, input logic [31:0] value);
        send_word(bqc_pkg::REQ_COEF, $urandom(), 6'(slot), value);
        if (slot < bqc_pkg::COEF_SLOTS) items_sent++;
    endtask

    task automatic tx_gap();
        int g;
        g = tx_steady ? 0 : pick_gap(1'b1);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Holds the sender back until every expected word has come out.
    task automatic tx_pause();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // A coefficient load gives no output word, so after the last word the block is
    // given a full sample's worth of cycles before anything is reconfigured.
    task automatic wait_idle();
        tx_pause();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The monitor compares the returned value against its own copy of the register.
    task automatic apb_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stretches of ready and of stall, with whole phases of steady ready.
    // When the stimulus asks for it, ready is held low for a long stretch so that the output
    // register fills, the block finishes the next sample and then refuses further words.
    initial begin
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                if (!rx_steady) begin
                    i_out_ready <= 1'b0;
                    repeat (pick_gap(1'b0)) @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: too long without any word or register access moving means the block is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int          r;
        int          ns;
        int          n_active;
        int          n_samples;
        int          coef_style;
        int          sample_style;
        int          phase;
        logic [31:0] pw;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= bqc_pkg::REQ_SAMPLE;
        i_sample_in  <= '0;
        i_coef_index <= '0;
        i_coef_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. Straight after reset one section is active and every
        // coefficient is zero, so the first sample must come out as zero.
        apb_read(ADDR_NUM_STAGES);
        send_sample(32'h7fff_ffff);
        // Stage 0 gets full-scale and mid-scale words of both signs and the smallest positive word.
        send_coef(0, 32'h7fff_ffff);
        send_coef(1, 32'h8000_0000);
        send_coef(2, 32'h4000_0000);
        send_coef(3, 32'hc000_0000);
        send_coef(4, 32'h0000_0001);
        // Slots past the table are dropped, the highest encodable one included.
        send_coef(bqc_pkg::COEF_SLOTS, $urandom());
        send_coef(COEF_IDX_MAX, $urandom());
        send_sample(32'h8000_0000);
        send_sample(32'h7fff_ffff);
        send_sample(32'h0000_0000);
        send_sample(32'hffff_ffff);
        send_sample(32'h0000_0001);

        // No active sections: each sample gives zero and the history must be left alone.
        wait_idle();
        apb_write(ADDR_NUM_STAGES, 32'd0);
        apb_read(ADDR_NUM_STAGES);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        // A write to an address with no register behind it must not change the stage count.
        wait_idle();
        apb_write(ADDR_UNMAPPED, 32'd3);
        apb_read(ADDR_NUM_STAGES);
        send_sample(32'h1234_5678);

        // A count above the maximum behaves as the maximum; the last slot is loaded too.
        wait_idle();
        apb_write(ADDR_NUM_STAGES, 32'd15);
        apb_read(ADDR_NUM_STAGES);
        send_coef(bqc_pkg::COEF_SLOTS - 1, 32'h8000_0000);
        send_coef(bqc_pkg::COEF_SLOTS - bqc_pkg::TERMS, 32'h7fff_ffff);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);

        // Random phases. Each one picks a stage count, mostly loads a complete and ordered
        // coefficient set for the active sections, and then streams samples through them.
        // Some phases scatter loads instead, and stray loads to dropped slots turn up too.
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 8) ns = 0;
            else if (r < 16) ns = $urandom_range(bqc_pkg::MAX_STAGES + 1, 15);
            else ns = $urandom_range(1, bqc_pkg::MAX_STAGES);
            if (phase == 0) ns = bqc_pkg::MAX_STAGES;
            if (phase == 1) ns = 1;
            // Bits above the register's width are random; only the low nibble may matter.
            pw      = $urandom();
            pw[3:0] = 4'(ns);
            apb_write(ADDR_NUM_STAGES, pw);
            if ($urandom_range(0, 19) == 0) apb_write(ADDR_UNMAPPED, $urandom());
            apb_read(ADDR_NUM_STAGES);
            n_active   = (ns > bqc_pkg::MAX_STAGES) ? bqc_pkg::MAX_STAGES : ns;
            tx_steady  = ($urandom_range(0, 4) == 0);
            rx_steady  = ($urandom_range(0, 4) == 0);
            coef_style = $urandom_range(0, 2);

            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 5) != 0) begin
                    for (int k = 0; k < n_active * bqc_pkg::TERMS; k++) begin
                        send_coef(k, pick_coef(coef_style));
                        tx_gap();
                    end
                end else begin
                    repeat ($urandom_range(1, 12)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_coef($urandom_range(bqc_pkg::COEF_SLOTS, COEF_IDX_MAX),
                                      $urandom());
                        end else begin
                            send_coef($urandom_range(0, bqc_pkg::COEF_SLOTS - 1),
                                      pick_coef(coef_style));
                        end
                        tx_gap();
                    end
                end
            end

            // Long receiver stall while the sender keeps offering words back to back.
            if (phase == 1 || $urandom_range(0, 14) == 0) begin
                holds_asked++;
                tx_steady = 1'b1;
            end

            n_samples    = $urandom_range(8, 40);
            sample_style = $urandom_range(0, 2);
            for (int k = 0; k < n_samples; k++) begin
                // The odd coefficient change in the middle of a stream.
                if ($urandom_range(0, 29) == 0) begin
                    send_coef($urandom_range(0, COEF_IDX_MAX), pick_coef(coef_style));
                end
                send_sample(pick_sample(sample_style));
                if ((phase == 2 && k == n_samples / 2) || $urandom_range(0, 49) == 0) begin
                    tx_pause();
                end else begin
                    tx_gap();
                end
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
